[hw/rtl/tqvu_pkg.sv]
// shared types and constants for the tabular q value update block
// no dependencies; used by the interfaces, the top level and the checker
package tqvu_pkg;

  localparam int NUM_OBSERVATIONS_DEF = 16;
  localparam int NUM_ACTIONS_DEF      = 8;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int OBS_FW  = 4;
  localparam int ACT_FW  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RESET = 16'd55706;
  localparam logic [FRAC_W-1:0] DISCOUNT_RESET   = 16'd62259;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 2'd1;

  // input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      mode;
    logic [OBS_FW-1:0]         observation;
    logic [ACT_FW-1:0]         action;
    logic signed [VALUE_W-1:0] reward;
    logic [OBS_FW-1:0]         next_observation;
    logic                      final_step;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_value;
    logic [ACT_FW-1:0]         greedy_next_action;
    logic                      saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OLD,
    ST_BOOT,
    ST_DIFF,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/tqvu_in_if.sv]
// input channel of the q value update block: valid, ready and one input item
// depends on tqvu_pkg
interface tqvu_in_if;
  logic               valid;
  logic               ready;
  tqvu_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tqvu_out_if.sv]
// output channel of the q value update block: valid, ready and one result item
// depends on tqvu_pkg
interface tqvu_out_if;
  logic                valid;
  logic                ready;
  tqvu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tqvu_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module tqvu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/tabular_q_value_update.sv]
// top level of the tabular q value update block
// depends on tqvu_pkg, tqvu_in_if, tqvu_out_if and tqvu_ram
//
// keeps a table of signed q16.16 values, one per observation and action, in a
// single ram with one read and one write port. a load item (mode 0) writes its
// value into the entry at the accept edge and goes straight to the done state
// with its result. an update item (mode 1) walks the row of next_observation
// one entry per cycle through the ram read port to find the greedy action
// (first maximum wins), reads the old entry, then forms gamma*q and the target
// in one step, alpha*(target - old) in another and the saturated sum in a last
// one, and writes the entry back. an update item therefore holds the block
// longer than a load item, and its stay grows with NUM_ACTIONS, as the row walk
// goes through the single ram read port. items are taken one at a time. the
// result sits in an output register, so the block returns to idle and takes
// the next item while that result waits for its transfer; a result only stalls
// the block when a second one is ready before the first has gone. out of range
// observation and action indexes clamp to the last row or column. the table has
// no reset: entries must be loaded before an update reads them. learn_rate and
// discount are to be written through the cfg port only while the block is idle;
// the user must ensure this, as the block itself does not enforce it
module tabular_q_value_update #(
  parameter int NUM_OBSERVATIONS = tqvu_pkg::NUM_OBSERVATIONS_DEF,
  parameter int NUM_ACTIONS      = tqvu_pkg::NUM_ACTIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tqvu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tqvu_pkg::CFG_DATA_W-1:0]     cfg_data,
  tqvu_in_if.sink                             in_ch,
  tqvu_out_if.source                          out_ch
);

  localparam int DEPTH  = NUM_OBSERVATIONS * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OBS_W  = $clog2(NUM_OBSERVATIONS);
  localparam int ACT_W  = $clog2(NUM_ACTIONS);
  localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
  localparam int VW     = tqvu_pkg::VALUE_W;
  localparam int FW     = tqvu_pkg::FRAC_W;

  // widths of the fixed point chain
  localparam int P1_W   = VW + FW + 1;    // q * gamma
  localparam int BOOT_W = P1_W - FW;      // rounded bootstrap term
  localparam int U_W    = VW + 2;         // target
  localparam int DIFF_W = U_W + 1;        // target - old
  localparam int P2_W   = DIFF_W + FW + 1; // diff * alpha
  localparam int Q2_W   = P2_W - FW;      // rounded step
  localparam int SUM_W  = Q2_W + 1;       // old + step

  localparam logic signed [P1_W-1:0] RND1 = P1_W'(1) <<< (FW - 1);
  localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) <<< (FW - 1);

  tqvu_pkg::state_t state, state_next;

  // configuration registers
  logic [FW-1:0] learn_rate;
  logic [FW-1:0] discount;

  // item registers
  logic [ADDR_W-1:0]         slot;
  logic [ADDR_W-1:0]         row_base;
  logic signed [VW-1:0]      reward;
  logic                      final_step;
  logic [CNT_W-1:0]          scan_cnt;
  logic signed [VW-1:0]      best_val;
  logic [ACT_W-1:0]          best_idx;
  logic signed [VW-1:0]      old_val;
  logic signed [U_W-1:0]     target;
  logic signed [P2_W-1:0]    step_prod;

  // result register, waits in done until the output register is free
  tqvu_pkg::out_item_t res;
  tqvu_pkg::out_item_t out_data;
  logic                out_valid;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VW-1:0]     ram_rdata;

  // index clamp and address of the incoming item
  logic [OBS_W-1:0]  in_obs;
  logic [OBS_W-1:0]  in_nobs;
  logic [ACT_W-1:0]  in_act;
  logic [ADDR_W-1:0] in_slot;
  logic [ADDR_W-1:0] in_row_base;
  logic              in_xfer;
  logic              out_free;
  logic              scan_issue;
  logic [ACT_W-1:0]  cmp_idx;

  // arithmetic
  logic signed [P1_W-1:0]   boot_prod;
  logic signed [P1_W-1:0]   boot_rnd;
  logic signed [BOOT_W-1:0] boot;
  logic signed [U_W-1:0]    target_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [P2_W-1:0]   step_prod_next;
  logic signed [P2_W-1:0]   step_rnd;
  logic signed [Q2_W-1:0]   step;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_ovf;
  logic signed [VW-1:0]     sum_sat;

  always_comb begin
    in_obs  = (32'(in_ch.data.observation) >= NUM_OBSERVATIONS) ?
              OBS_W'(NUM_OBSERVATIONS - 1) : OBS_W'(in_ch.data.observation);
    in_nobs = (32'(in_ch.data.next_observation) >= NUM_OBSERVATIONS) ?
              OBS_W'(NUM_OBSERVATIONS - 1) : OBS_W'(in_ch.data.next_observation);
    in_act  = (32'(in_ch.data.action) >= NUM_ACTIONS) ?
              ACT_W'(NUM_ACTIONS - 1) : ACT_W'(in_ch.data.action);
    in_slot     = ADDR_W'(32'(in_obs) * NUM_ACTIONS + 32'(in_act));
    in_row_base = ADDR_W'(32'(in_nobs) * NUM_ACTIONS);
  end

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid || out_ch.ready;
  assign scan_issue = 32'(scan_cnt) < NUM_ACTIONS;
  assign cmp_idx    = ACT_W'(scan_cnt - CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tqvu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = (in_ch.data.mode == tqvu_pkg::MODE_LOAD) ?
                       tqvu_pkg::ST_DONE : tqvu_pkg::ST_SCAN;
        end
      end
      tqvu_pkg::ST_SCAN: begin
        if (!scan_issue) begin
          state_next = tqvu_pkg::ST_OLD;
        end
      end
      tqvu_pkg::ST_OLD:  state_next = tqvu_pkg::ST_BOOT;
      tqvu_pkg::ST_BOOT: state_next = tqvu_pkg::ST_DIFF;
      tqvu_pkg::ST_DIFF: state_next = tqvu_pkg::ST_SUM;
      tqvu_pkg::ST_SUM:  state_next = tqvu_pkg::ST_DONE;
      tqvu_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tqvu_pkg::ST_IDLE;
        end
      end
      default: state_next = tqvu_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and ram accesses
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot;
    ram_wdata   = sum_sat;
    ram_re      = 1'b0;
    ram_raddr   = slot;
    unique case (state)
      tqvu_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        // a load writes straight through at the accept edge
        if (in_xfer && in_ch.data.mode == tqvu_pkg::MODE_LOAD) begin
          ram_we    = 1'b1;
          ram_waddr = in_slot;
          ram_wdata = in_ch.data.reward;
        end
      end
      tqvu_pkg::ST_SCAN: begin
        // one row entry per cycle, then the old entry itself
        ram_re    = 1'b1;
        ram_raddr = scan_issue ? ADDR_W'(row_base + ADDR_W'(scan_cnt)) : slot;
      end
      tqvu_pkg::ST_SUM: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // bootstrap term and target
  always_comb begin
    boot_prod   = best_val * $signed({1'b0, discount});
    boot_rnd    = boot_prod + RND1;
    boot        = boot_rnd[P1_W-1:FW];
    target_next = {{(U_W - VW){reward[VW-1]}}, reward};
    if (!final_step) begin
      target_next = target_next + {{(U_W - BOOT_W){boot[BOOT_W-1]}}, boot};
    end
  end

  // learning step
  always_comb begin
    diff = {{(DIFF_W - U_W){target[U_W-1]}}, target}
         - {{(DIFF_W - VW){old_val[VW-1]}}, old_val};
    step_prod_next = diff * $signed({1'b0, learn_rate});
  end

  // rounding, sum and saturation
  always_comb begin
    step_rnd = step_prod + RND2;
    step     = step_rnd[P2_W-1:FW];
    sum      = {step[Q2_W-1], step} + {{(SUM_W - VW){old_val[VW-1]}}, old_val};
    sum_ovf  = !((&sum[SUM_W-1:VW-1]) || !(|sum[SUM_W-1:VW-1]));
    if (!sum_ovf) begin
      sum_sat = sum[VW-1:0];
    end else if (sum[SUM_W-1]) begin
      sum_sat = tqvu_pkg::VALUE_MIN;
    end else begin
      sum_sat = tqvu_pkg::VALUE_MAX;
    end
  end

  tqvu_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tqvu_pkg::ST_IDLE;
      learn_rate <= tqvu_pkg::LEARN_RATE_RESET;
      discount   <= tqvu_pkg::DISCOUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        priority case (cfg_index)
          tqvu_pkg::REG_LEARN_RATE: learn_rate <= cfg_data;
          tqvu_pkg::REG_DISCOUNT:   discount   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == tqvu_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      tqvu_pkg::ST_IDLE: begin
        slot       <= in_slot;
        row_base   <= in_row_base;
        reward     <= in_ch.data.reward;
        final_step <= in_ch.data.final_step;
        scan_cnt   <= '0;
        res.new_value          <= in_ch.data.reward;
        res.greedy_next_action <= '0;
        res.saturated          <= 1'b0;
      end
      tqvu_pkg::ST_SCAN: begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        // ram data belongs to the entry issued in the cycle before
        if (scan_cnt != '0) begin
          if (scan_cnt == CNT_W'(1) || $signed(ram_rdata) > best_val) begin
            best_val <= ram_rdata;
            best_idx <= cmp_idx;
          end
        end
      end
      tqvu_pkg::ST_OLD: begin
        old_val <= ram_rdata;
      end
      tqvu_pkg::ST_BOOT: begin
        target <= target_next;
      end
      tqvu_pkg::ST_DIFF: begin
        step_prod <= step_prod_next;
      end
      tqvu_pkg::ST_SUM: begin
        res.new_value          <= sum_sat;
        res.greedy_next_action <= tqvu_pkg::ACT_FW'(best_idx);
        res.saturated          <= sum_ovf;
      end
      tqvu_pkg::ST_DONE: begin
        if (out_free) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

[hw/rtl/tqvu_checker.sv]
// port level checks of the q value update block, bound to the top level
// depends on tqvu_pkg and tabular_q_value_update
module tqvu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tqvu_pkg::out_item_t out_data
);

  // a result waiting for its transfer stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: the block is busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a clipped result is one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.new_value == tqvu_pkg::VALUE_MAX ||
       out_data.new_value == tqvu_pkg::VALUE_MIN))
    else $error("saturated result not at a limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tabular_q_value_update tqvu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[dv/tqvu_update_check.sv]
// watches both channels and the cfg port of the q value update block, predicts every result
// from its own copy of the table and registers, and compares the results in order
// depends on tqvu_pkg, tqvu_in_if and tqvu_out_if
`timescale 1ns / 100ps

module tqvu_update_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tqvu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tqvu_pkg::CFG_DATA_W-1:0]   cfg_data,
  tqvu_in_if                                in_ch,
  tqvu_out_if                               out_ch,
  output int                                errors,
  output int                                pending,
  output int                                checked
);
  import tqvu_pkg::*;

  localparam int ROWS = NUM_OBSERVATIONS_DEF;
  localparam int COLS = NUM_ACTIONS_DEF;

  logic signed [VALUE_W-1:0] q_table [ROWS*COLS];
  logic [FRAC_W-1:0]         alpha_frac;
  logic [FRAC_W-1:0]         gamma_frac;
  out_item_t                 entry_results_q[$];
  int                        err_cnt;
  int                        chk_cnt;

  function automatic int clamp_idx(int v, int lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // x * f / 65536 with round half up, floor on the signed sum
  function automatic longint scale_frac(longint x, logic [FRAC_W-1:0] f);
    longint p;
    p = x * longint'(f) + 64'sd32768;
    return p >>> FRAC_W;
  endfunction

  // applies one transfer to the table copy and returns the entry it leaves behind
  function automatic out_item_t step_q_table(in_item_t it);
    int                        row_nx;
    int                        slot;
    logic signed [VALUE_W-1:0] rew;
    logic signed [VALUE_W-1:0] best_v;
    logic signed [VALUE_W-1:0] old_v;
    logic [ACT_FW-1:0]         best_a;
    longint                    target;
    longint                    total;
    out_item_t                 r;
    r      = '0;
    rew    = it.reward;
    slot   = clamp_idx(int'(it.observation), ROWS) * COLS + clamp_idx(int'(it.action), COLS);
    row_nx = clamp_idx(int'(it.next_observation), ROWS) * COLS;
    if (it.mode == MODE_LOAD) begin
      q_table[slot] = rew;
      r.new_value   = rew;
    end else begin
      // greedy search over the row as it stands before this write, first maximum wins
      best_v = q_table[row_nx];
      best_a = '0;
      for (int i = 1; i < COLS; i++) begin
        if (q_table[row_nx + i] > best_v) begin
          best_v = q_table[row_nx + i];
          best_a = ACT_FW'(i);
        end
      end
      old_v  = q_table[slot];
      target = longint'(rew);
      if (!it.final_step) target += scale_frac(longint'(best_v), gamma_frac);
      total = longint'(old_v) + scale_frac(target - longint'(old_v), alpha_frac);
      if (total > longint'(VALUE_MAX)) begin
        total       = longint'(VALUE_MAX);
        r.saturated = 1'b1;
      end else if (total < longint'(VALUE_MIN)) begin
        total       = longint'(VALUE_MIN);
        r.saturated = 1'b1;
      end
      r.new_value          = total[VALUE_W-1:0];
      r.greedy_next_action = best_a;
      q_table[slot]        = r.new_value;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      alpha_frac = LEARN_RATE_RESET;
      gamma_frac = DISCOUNT_RESET;
      entry_results_q.delete();
      err_cnt = 0;
      chk_cnt = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (entry_results_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, actual new_value %h action %0d sat %0b",
                   $time, got.new_value, got.greedy_next_action, got.saturated);
        end else begin
          want = entry_results_q.pop_front();
          chk_cnt++;
          if (got.new_value !== want.new_value) begin
            err_cnt++;
            $display("%0t: new_value expected %h, actual %h",
                     $time, want.new_value, got.new_value);
          end
          if (got.greedy_next_action !== want.greedy_next_action) begin
            err_cnt++;
            $display("%0t: greedy_next_action expected %0d, actual %0d",
                     $time, want.greedy_next_action, got.greedy_next_action);
          end
          if (got.saturated !== want.saturated) begin
            err_cnt++;
            $display("%0t: saturated expected %0b, actual %0b",
                     $time, want.saturated, got.saturated);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) entry_results_q.push_back(step_q_table(in_ch.data));
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARN_RATE: alpha_frac = cfg_data;
          REG_DISCOUNT:   gamma_frac = cfg_data;
          default: ;
        endcase
      end
    end
    errors  <= err_cnt;
    pending <= entry_results_q.size();
    checked <= chk_cnt;
  end

endmodule

[dv/tb_top.sv]
// top of the q value update testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on tqvu_pkg, the two channel interfaces, the block and tqvu_update_check
`timescale 1ns / 100ps

module tb_top;
  import tqvu_pkg::*;

  localparam int ROWS  = NUM_OBSERVATIONS_DEF;
  localparam int COLS  = NUM_ACTIONS_DEF;
  localparam int SLOTS = ROWS * COLS;
  // the slowest item takes an input gap, the walk of the row and an output stall;
  // about 525 items and the long hold-off stay far below this limit
  localparam longint RUN_LIMIT_NS = 64'd3_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // flags from the stimulus process to the receiver, written only there
  logic quiet        = 1'b0;
  logic pressure_req = 1'b0;

  int errors;
  int pending;
  int checked;

  int n_loads    = 0;
  int n_updates  = 0;
  int n_settings = 1;

  // entries loaded so far; updates only ever read these
  logic [SLOTS-1:0] loaded = '0;

  // row 0 has a three way tie at the top so the first maximum decides
  logic signed [VALUE_W-1:0] row0_vals [COLS] = '{
    32'sh0001_0000, -32'sd1, 32'sh0002_0000, 32'sh0002_0000,
    VALUE_MIN, 32'sd5, 32'sh0002_0000, 32'sd0
  };

  tqvu_in_if  in_ch ();
  tqvu_out_if out_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tabular_q_value_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tqvu_update_check i_update_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // offers one item and returns at the edge of its transfer; a random gap may come first
  task automatic offer(logic m, int o, int a, logic signed [VALUE_W-1:0] v, int n, logic f);
    in_item_t it;
    it.mode             = m;
    it.observation      = o[OBS_FW-1:0];
    it.action           = a[ACT_FW-1:0];
    it.reward           = v;
    it.next_observation = n[OBS_FW-1:0];
    it.final_step       = f;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (m == MODE_LOAD) begin
      loaded[o * COLS + a] = 1'b1;
      n_loads++;
    end else begin
      n_updates++;
    end
  endtask

  // load with random ignored fields
  task automatic load_entry(int o, int a, logic signed [VALUE_W-1:0] v);
    offer(MODE_LOAD, o, a, v, $urandom_range(0, ROWS - 1), 1'($urandom_range(0, 1)));
  endtask

  // extremes, small multiples of one and of one lsb for ties, and raw random words
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int s;
    s = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 6))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return s * 65536;
      3:       return s;
      default: return $urandom;
    endcase
  endfunction

  // mostly updates over loaded rows; loads fill new rows in order or overwrite at random
  task automatic random_item();
    int  start;
    int  row;
    int  slot;
    int  gap_slot;
    bit  have_row;
    have_row = 1'b0;
    row      = 0;
    gap_slot = -1;
    start    = $urandom_range(0, ROWS - 1);
    for (int k = 0; k < ROWS; k++) begin
      if (!have_row && (&loaded[((start + k) % ROWS) * COLS +: COLS])) begin
        have_row = 1'b1;
        row      = (start + k) % ROWS;
      end
    end
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!loaded[k]) gap_slot = k;
    end
    if (!have_row || $urandom_range(0, 3) == 0) begin
      if (gap_slot >= 0 && $urandom_range(0, 1) == 0) slot = gap_slot;
      else slot = $urandom_range(0, SLOTS - 1);
      load_entry(slot / COLS, slot % COLS, pick_value());
    end else begin
      slot = $urandom_range(0, SLOTS - 1);
      while (!loaded[slot]) slot = (slot + 1) % SLOTS;
      offer(MODE_UPDATE, slot / COLS, slot % COLS, pick_value(), row,
            1'($urandom_range(0, 3) == 0));
    end
  endtask

  // stop offering and wait until every expected result has gone out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic set_regs(logic [CFG_DATA_W-1:0] lr, logic [CFG_DATA_W-1:0] dc);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEARN_RATE;
    cfg_data  <= lr;
    @(posedge clk);
    cfg_index <= REG_DISCOUNT;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // receiver: random stall bursts, one long hold-off on request, none in the quiet tail
  initial begin : receiver
    int  stall_left;
    int  hold_left;
    bit  pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        hold_left     = 120;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset values of alpha and gamma
    // row 0 gets a tie at the top, row 15 is all minimum so every action ties
    for (int a = 0; a < COLS; a++) load_entry(0, a, row0_vals[a]);
    for (int a = 0; a < COLS; a++) load_entry(ROWS - 1, a, VALUE_MIN);
    // same row as the one searched, all equal, target below the minimum: clips low
    offer(MODE_UPDATE, ROWS - 1, 3, VALUE_MIN, ROWS - 1, 1'b0);
    // tie in row 0 resolves to the first maximum, maximum reward
    offer(MODE_UPDATE, 0, 2, VALUE_MAX, 0, 1'b0);
    // maximum entry pushed further up: clips high
    load_entry(0, 5, VALUE_MAX);
    offer(MODE_UPDATE, 0, 5, VALUE_MAX, 0, 1'b0);
    // final step: no bootstrap, greedy action still reported
    offer(MODE_UPDATE, 0, 1, 32'sh0000_8000, ROWS - 1, 1'b1);
    offer(MODE_UPDATE, ROWS - 1, COLS - 1, -32'sh0001_0000, 0, 1'b0);

    // random part at reset settings, with one long receiver hold-off early on
    for (int i = 0; i < 150; i++) begin
      if (i == 20) pressure_req <= 1'b1;
      random_item();
    end

    // alpha and gamma at their top, then both at zero
    set_regs(16'hffff, 16'hffff);
    for (int i = 0; i < 100; i++) random_item();
    set_regs(16'h0000, 16'h0000);
    for (int i = 0; i < 60; i++) random_item();

    // a few random settings; the very last stretch runs with no idling at all
    for (int p = 0; p < 3; p++) begin
      set_regs(16'($urandom), 16'($urandom));
      for (int i = 0; i < 64; i++) begin
        if (p == 2 && i == 4) quiet <= 1'b1;
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d loads and %0d updates under %0d alpha/gamma settings",
             n_loads, n_updates, n_settings);
    $display("%0d results compared, long output hold-off included", checked);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
